>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the calendar clock RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Types, constants and month-length lookup for the calendar clock tick unit.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Wrap points of the counters
  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [4:0] HOUR_LAST  = 5'd23;
  localparam logic [2:0] WDAY_LAST  = 3'd7;
  localparam logic [3:0] MONTH_LAST = 4'd12;
  localparam logic [3:0] MONTH_FEB  = 4'd2;

  // Month lengths
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
  localparam logic [4:0] DAYS_FEB      = 5'd28;
  localparam logic [4:0] DAYS_SHORT    = 5'd30;
  localparam logic [4:0] DAYS_LONG     = 5'd31;

  // Reset values
  localparam logic [4:0]  RST_DAY   = 5'd1;
  localparam logic [3:0]  RST_MONTH = 4'd1;
  localparam logic [15:0] RST_YEAR  = 16'd2000;
  localparam logic [2:0]  RST_WDAY  = 3'd1;

  // Divisibility by 25 on 16 bits: y * inverse(25) mod 2^16 <= floor(65535 / 25)
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'(65535 / 25);

  typedef struct packed {
    logic        command;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [15:0] set_year;
    logic [2:0]  set_weekday;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [15:0] year_now;
    logic [2:0]  weekday_now;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  seconds_count;
    logic [5:0]  minutes_count;
    logic [4:0]  hours_count;
    logic [4:0]  day_of_month;
    logic [3:0]  month_of_year;
    logic [15:0] year_count;
    logic [2:0]  day_of_week;
  } cal_state_t;

  // Handshake between the input register and the state stage
  typedef struct packed {
    logic valid;
    logic ready;
  } hold_ctl_t;

  // Length of a month; undefined month codes count as long months
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    days = DAYS_LONG;
    case (month)
      4'd2:    days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      4'd4:    days = DAYS_SHORT;
      4'd6:    days = DAYS_SHORT;
      4'd9:    days = DAYS_SHORT;
      4'd11:   days = DAYS_SHORT;
      default: days = DAYS_LONG;
    endcase
    return days;
  endfunction

endpackage

>>> hdl/cct_in_reg.sv
// ----------------------------------------------------------------------------
// cct_in_reg
// Input register: captures one beat and holds it until the state stage takes it.
// ----------------------------------------------------------------------------
module cct_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cct_pkg::in_item_t in_item,
  input  logic              take_ok,
  output cct_pkg::hold_ctl_t hold_ctl,
  output cct_pkg::in_item_t hold_item
);

  logic              valid_r;
  logic              valid_nxt;
  cct_pkg::in_item_t item_r;

  // Accept when empty or when the held beat leaves this cycle
  assign in_ready = !valid_r || take_ok;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take_ok) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign hold_ctl.valid = valid_r;
  assign hold_ctl.ready = take_ok;
  assign hold_item      = item_r;

endmodule

>>> hdl/cct_next.sv
// ----------------------------------------------------------------------------
// cct_next
// Next calendar state for one beat: load on set, cascaded advance on tick.
// ----------------------------------------------------------------------------
module cct_next (
  input  cct_pkg::cal_state_t cur,
  input  cct_pkg::in_item_t   item,
  output cct_pkg::cal_state_t nxt
);

  logic [15:0] year_prod;
  logic        div4;
  logic        div16;
  logic        div25;
  logic        leap;
  logic [4:0]  days;

  // Gregorian leap rule without a divider
  assign year_prod = 16'(cur.year_count * cct_pkg::INV25);
  assign div4      = (cur.year_count[1:0] == 2'd0);
  assign div16     = (cur.year_count[3:0] == 4'd0);
  assign div25     = (year_prod <= cct_pkg::DIV25_LIMIT);
  assign leap      = div4 && (!div25 || div16);
  assign days      = cct_pkg::month_days(cur.month_of_year, leap);

  always_comb begin
    nxt = cur;
    if (item.command == cct_pkg::CMD_SET) begin
      // Load every field as given
      nxt.hours_count   = item.set_hour;
      nxt.minutes_count = item.set_minute;
      nxt.seconds_count = item.set_second;
      nxt.day_of_month  = item.set_day;
      nxt.month_of_year = item.set_month;
      nxt.year_count    = item.set_year;
      nxt.day_of_week   = item.set_weekday;
    end else if (cur.seconds_count < cct_pkg::SEC_LAST) begin
      nxt.seconds_count = 6'(cur.seconds_count + 6'd1);
    end else begin
      nxt.seconds_count = 6'd0;
      if (cur.minutes_count < cct_pkg::MIN_LAST) begin
        nxt.minutes_count = 6'(cur.minutes_count + 6'd1);
      end else begin
        nxt.minutes_count = 6'd0;
        if (cur.hours_count < cct_pkg::HOUR_LAST) begin
          nxt.hours_count = 5'(cur.hours_count + 5'd1);
        end else begin
          nxt.hours_count = 5'd0;
          // Advance weekday and date
          nxt.day_of_week = (cur.day_of_week >= cct_pkg::WDAY_LAST) ?
                            3'd1 : 3'(cur.day_of_week + 3'd1);
          if (cur.day_of_month >= days) begin
            nxt.day_of_month = 5'd1;
            if (cur.month_of_year >= cct_pkg::MONTH_LAST) begin
              nxt.month_of_year = 4'd1;
              nxt.year_count    = 16'(cur.year_count + 16'd1);
            end else begin
              nxt.month_of_year = 4'(cur.month_of_year + 4'd1);
            end
          end else begin
            nxt.day_of_month = 5'(cur.day_of_month + 5'd1);
          end
        end
      end
    end
  end

endmodule

>>> hdl/calendar_clock_tick_unit.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick_unit
// Real-time clock and calendar: one-second ticks and full time loads.
// ----------------------------------------------------------------------------
//  channel | ports                         | beat carries
//  --------+-------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_item   | command and set fields
//  result  | out_valid, out_ready, out_item| time fields after the beat
//
//  One beat per cycle sustained while out_ready holds; the result is valid
//  once the beat has passed the input register, then the state register.
//  The calendar state register doubles as the result register.
//  Reset (rst_n low, synchronous) clears both stages and loads 00:00:00,
//  day 1, month 1, year 2000, weekday 1.
//  A stalled result holds the state stage; the input register takes one more
//  beat before in_ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_clock_tick_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cct_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cct_pkg::out_item_t out_item
);

  cct_pkg::hold_ctl_t  hold_ctl;
  cct_pkg::in_item_t   hold_item;
  cct_pkg::cal_state_t state_r;
  cct_pkg::cal_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_free;
  logic                advance;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = hold_ctl.valid && out_free;

  cct_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .take_ok   (advance),
    .hold_ctl  (hold_ctl),
    .hold_item (hold_item)
  );

  cct_next u_next (
    .cur  (state_r),
    .item (hold_item),
    .nxt  (state_nxt)
  );

  // Update calendar state when a beat moves into the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.seconds_count <= 6'd0;
      state_r.minutes_count <= 6'd0;
      state_r.hours_count   <= 5'd0;
      state_r.day_of_month  <= cct_pkg::RST_DAY;
      state_r.month_of_year <= cct_pkg::RST_MONTH;
      state_r.year_count    <= cct_pkg::RST_YEAR;
      state_r.day_of_week   <= cct_pkg::RST_WDAY;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result valid: set on advance, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item.hour_now    = state_r.hours_count;
  assign out_item.minute_now  = state_r.minutes_count;
  assign out_item.second_now  = state_r.seconds_count;
  assign out_item.day_now     = state_r.day_of_month;
  assign out_item.month_now   = state_r.month_of_year;
  assign out_item.year_now    = state_r.year_count;
  assign out_item.weekday_now = state_r.day_of_week;

  // Checks
  property p_state_hold;
    rst_n && !advance |=> $stable(state_r);
  endproperty

  property p_sec_step;
    advance && hold_item.command == cct_pkg::CMD_TICK &&
    state_r.seconds_count < cct_pkg::SEC_LAST |=>
    state_r.seconds_count == 6'($past(state_r.seconds_count) + 6'd1) &&
    $stable(state_r.minutes_count);
  endproperty

  property p_hold_keep;
    rst_n && hold_ctl.valid && !out_free |=> hold_ctl.valid && $stable(hold_item);
  endproperty

  `CCT_ASSERT(a_state_hold, clk, rst_n, p_state_hold, "state changed without a beat")
  `CCT_ASSERT(a_sec_step, clk, rst_n, p_sec_step, "tick did not step seconds alone")
  `CCT_ASSERT(a_hold_keep, clk, rst_n, p_hold_keep, "held beat lost during a stall")

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for calendar_clock_tick_unit. A short directed table
// covers counter wraps, leap-year rules, month ends, year overflow and
// out-of-range loads. Random set/tick sequences follow, most of them loading a
// time just before midnight at a month end so that the day, month and year
// carries fire often. Every result beat is checked against a cycle-free
// calendar predictor. Both channels idle at random, and the result side
// holds off once for a long stretch so that the pipeline backs up.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1300;
  localparam int STALL_LIMIT  = 1000;
  localparam int LONG_HOLD    = 150;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    cct_pkg::in_item_t  stim;
    bit                 typed;
    cct_pkg::out_item_t want;
  } dir_row_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  cct_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cct_pkg::out_item_t out_item;

  cct_pkg::out_item_t clock_now;
  cct_pkg::out_item_t pending_times[$];
  dir_row_t           dir_rows[$];
  int                 mismatch_count = 0;
  int                 idle_cycles    = 0;
  int                 beats_sent     = 0;
  bit                 hold_request   = 1'b0;

  calendar_clock_tick_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #10 clk = ~clk;

  // Calendar helpers
  function automatic bit leap_year(input logic [15:0] yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] mon, input logic [15:0] yr);
    case (mon)
      4'd2:                   return leap_year(yr) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                return 5'd31;
    endcase
  endfunction

  function automatic cct_pkg::out_item_t time_of(input int hh, input int mm, input int ss,
                                                 input int dd, input int mo, input int yr,
                                                 input int wd);
    cct_pkg::out_item_t t;
    t.hour_now    = 5'(hh);
    t.minute_now  = 6'(mm);
    t.second_now  = 6'(ss);
    t.day_now     = 5'(dd);
    t.month_now   = 4'(mo);
    t.year_now    = 16'(yr);
    t.weekday_now = 3'(wd);
    return t;
  endfunction

  function automatic cct_pkg::in_item_t load_of(input cct_pkg::out_item_t t);
    cct_pkg::in_item_t it;
    it.command     = cct_pkg::CMD_SET;
    it.set_hour    = t.hour_now;
    it.set_minute  = t.minute_now;
    it.set_second  = t.second_now;
    it.set_day     = t.day_now;
    it.set_month   = t.month_now;
    it.set_year    = t.year_now;
    it.set_weekday = t.weekday_now;
    return it;
  endfunction

  function automatic cct_pkg::in_item_t noise_beat(input logic cmd);
    logic [63:0]       raw;
    cct_pkg::in_item_t it;
    raw        = {$urandom, $urandom};
    it         = raw[$bits(cct_pkg::in_item_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  // Predict the clock after one beat
  function automatic cct_pkg::out_item_t advance_clock(input cct_pkg::out_item_t cur,
                                                       input cct_pkg::in_item_t it);
    cct_pkg::out_item_t nxt;
    nxt = cur;
    if (it.command == cct_pkg::CMD_SET) begin
      nxt = time_of(it.set_hour, it.set_minute, it.set_second, it.set_day,
                    it.set_month, it.set_year, it.set_weekday);
    end else if (nxt.second_now < 6'd59) begin
      nxt.second_now = nxt.second_now + 6'd1;
    end else begin
      nxt.second_now = '0;
      if (nxt.minute_now < 6'd59) begin
        nxt.minute_now = nxt.minute_now + 6'd1;
      end else begin
        nxt.minute_now = '0;
        if (nxt.hour_now < 5'd23) begin
          nxt.hour_now = nxt.hour_now + 5'd1;
        end else begin
          // Midnight: advance weekday and date
          nxt.hour_now    = '0;
          nxt.weekday_now = (nxt.weekday_now >= 3'd7) ? 3'd1 : nxt.weekday_now + 3'd1;
          if (nxt.day_now >= month_length(nxt.month_now, nxt.year_now)) begin
            nxt.day_now = 5'd1;
            if (nxt.month_now >= 4'd12) begin
              nxt.month_now = 4'd1;
              nxt.year_now  = nxt.year_now + 16'd1;
            end else begin
              nxt.month_now = nxt.month_now + 4'd1;
            end
          end else begin
            nxt.day_now = nxt.day_now + 5'd1;
          end
        end
      end
    end
    return nxt;
  endfunction

  // Load a time a few seconds before a likely rollover
  function automatic cct_pkg::in_item_t rollover_load();
    logic [15:0] yr;
    logic [3:0]  mon;
    logic [4:0]  dd;
    case ($urandom_range(0, 4))
      0:       yr = 16'($urandom);
      1:       yr = 16'(400 * $urandom_range(0, 163));
      2:       yr = 16'(100 * $urandom_range(0, 655));
      3:       yr = 16'(4 * $urandom_range(0, 16383));
      default: yr = 16'hFFFF;
    endcase
    mon = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
    if ($urandom_range(0, 3) == 0)
      dd = 5'($urandom_range(0, 31));
    else
      dd = month_length(mon, yr) - 5'($urandom_range(0, 1));
    return load_of(time_of(($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59,
                           $urandom_range(50, 59), dd, mon, yr, $urandom_range(0, 7)));
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offer one beat, wait for accept, record the expected time
  task automatic send_beat(input cct_pkg::in_item_t it, input bit typed,
                           input cct_pkg::out_item_t want);
    int gap;
    gap = ((beats_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    clock_now = advance_clock(clock_now, it);
    pending_times.push_back(typed ? want : clock_now);
    beats_sent++;
  endtask

  // Directed rows: wraps, leap rules, month ends, out-of-range loads
  task automatic build_directed();
    dir_row_t r;
    r.typed = 1'b1;
    r.stim  = noise_beat(cct_pkg::CMD_TICK);
    r.want  = time_of(0, 0, 1, 1, 1, 2000, 1);
    dir_rows.push_back(r);
    r.want  = time_of(23, 59, 59, 31, 12, 65535, 7);
    r.stim  = load_of(r.want);
    dir_rows.push_back(r);
    r.stim  = noise_beat(cct_pkg::CMD_TICK);
    r.want  = time_of(0, 0, 0, 1, 1, 0, 1);
    dir_rows.push_back(r);
    r.want  = time_of(31, 63, 63, 31, 15, 0, 0);
    r.stim  = load_of(r.want);
    dir_rows.push_back(r);
    r.typed = 1'b0;
    r.stim  = noise_beat(cct_pkg::CMD_TICK);
    dir_rows.push_back(r);
    // Leap years by 400, by 4, not by 100, plain years, short months,
    // day and month zero, month zero at day 31, minute and hour overrange
    r.stim = load_of(time_of(23, 59, 59, 28, 2, 2000, 7));  dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(23, 59, 59, 29, 2, 2000, 3));  dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(23, 59, 59, 28, 2, 1900, 4));  dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(23, 59, 59, 28, 2, 2024, 5));  dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(23, 59, 59, 28, 2, 2023, 6));  dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(23, 59, 59, 30, 4, 2023, 2));  dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(23, 59, 59, 0, 0, 100, 0));    dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(23, 59, 59, 31, 0, 100, 7));   dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(10, 60, 60, 15, 6, 2000, 2));  dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
    r.stim = load_of(time_of(24, 59, 59, 15, 6, 2000, 2));  dir_rows.push_back(r);
    r.stim = noise_beat(cct_pkg::CMD_TICK);                 dir_rows.push_back(r);
  endtask

  // Stimulus and end of run
  initial begin
    int ticks_left;
    clock_now = time_of(0, 0, 0, cct_pkg::RST_DAY, cct_pkg::RST_MONTH,
                        cct_pkg::RST_YEAR, cct_pkg::RST_WDAY);
    build_directed();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) send_beat(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    ticks_left = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 3) hold_request = 1'b1;
      if (ticks_left > 0) begin
        send_beat(noise_beat(cct_pkg::CMD_TICK), 1'b0, clock_now);
        ticks_left--;
      end else begin
        send_beat(($urandom_range(0, 3) == 0) ? noise_beat(cct_pkg::CMD_SET) : rollover_load(),
                  1'b0, clock_now);
        ticks_left = $urandom_range(1, 40);
      end
    end
    in_valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    int beats_taken;
    beats_taken = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = ((beats_taken / 50) % 4 == 1) ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
      beats_taken++;
    end
  end

  // Check each result beat against the oldest expected time
  always @(posedge clk) begin
    cct_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_times.size() == 0) begin
        $error("result beat with no expected time pending");
        mismatch_count++;
      end else begin
        want = pending_times.pop_front();
        check_field("hour_now",    want.hour_now,    out_item.hour_now);
        check_field("minute_now",  want.minute_now,  out_item.minute_now);
        check_field("second_now",  want.second_now,  out_item.second_now);
        check_field("day_now",     want.day_now,     out_item.day_now);
        check_field("month_now",   want.month_now,   out_item.month_now);
        check_field("year_now",    want.year_now,    out_item.year_now);
        check_field("weekday_now", want.weekday_now, out_item.weekday_now);
      end
    end
  end

  // Watchdog: abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cct_pkg.sv
hdl/cct_in_reg.sv
hdl/cct_next.sv
hdl/calendar_clock_tick_unit.sv
dv/tb.sv
